[rtl/eebr_pkg.sv]
// Package for the encoder error bin recorder.
// Holds field widths, table constants and the controller/datapath interface types.
// Depends on nothing; every other file imports it.
package eebr_pkg;

    // Field widths of the item and result channels.
    localparam int POS_W  = 32;
    localparam int BIN_W  = 12;
    localparam int CORR_W = 16;

    // Correction table size and address width.
    localparam int TABLE_SIZE = 4096;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);

    // Table marker for an entry that holds no data, and the correction limit.
    localparam logic signed [CORR_W-1:0] NO_DATA_MARK = 16'sh8000;
    localparam logic [CORR_W-2:0]        CORR_MAG_MAX = 15'h7fff;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the item's fields
        logic accumulate;  // add the difference to the sum and bump the count
        logic div_start;   // set up the divider from sum and count
        logic div_step;    // one restoring division step
        logic div_end;     // sign, clamp, write table, restart the bin
        logic tbl_clear;   // write the no-data marker at the clear address
        logic rd_query;    // read the table at the query index
        logic load_out;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enable;      // recording enabled
        logic bin_change;  // item's bin differs from the previous bin
        logic div_done;    // this divider step is the last one
        logic clr_done;    // this clear write is the last one
    } stat_t;

endpackage

[rtl/encoder_error_bin_recorder.sv]
// An item whose bin matches the previous bin passes through the accumulate, read and
// output states; a bin change adds a 32-step restoring divider before the read.
// A new item is taken only in the idle state, so each item is finished before the next.
// The next item is accepted while the previous result waits in the output register.
// Reset (aresetn, synchronous, active low) starts a pass that fills the
// table with the no-data marker; no item is accepted until it ends.
module encoder_error_bin_recorder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [eebr_pkg::POS_W-1:0]  s_motor_position,
    input  logic signed [eebr_pkg::POS_W-1:0]  s_encoder_position,
    input  logic [eebr_pkg::BIN_W-1:0]         s_bin_now,
    input  logic [eebr_pkg::BIN_W-1:0]         s_query_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [eebr_pkg::CORR_W-1:0] m_correction,
    output logic                               m_table_written,
    output logic [eebr_pkg::BIN_W-1:0]         m_written_bin,
    output logic signed [eebr_pkg::CORR_W-1:0] m_query_value
);
    import eebr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller.
    eebr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath.
    eebr_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_motor_position   (s_motor_position),
        .s_encoder_position (s_encoder_position),
        .s_bin_now          (s_bin_now),
        .s_query_index      (s_query_index),
        .m_correction       (m_correction),
        .m_table_written    (m_table_written),
        .m_written_bin      (m_written_bin),
        .m_query_value      (m_query_value)
    );

endmodule

[rtl/eebr_ctrl.sv]
// Controller state machine of the encoder error bin recorder.
// Sequences the table clear, accumulation, division, table write and query read.
// Depends on eebr_pkg.
module eebr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  eebr_pkg::stat_t stat,
    output eebr_pkg::cmd_t  cmd
);
    import eebr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Commands decoded from the current state.
    always_comb begin
        cmd           = '0;
        cmd.tbl_clear = (state_reg == ST_CLEAR);
        cmd.load_item = (state_reg == ST_IDLE) && s_valid;
        cmd.accumulate = (state_reg == ST_ACC) && stat.enable;
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.div_step  = (state_reg == ST_DIV_STEP);
        cmd.div_end   = (state_reg == ST_DIV_END);
        cmd.rd_query  = (state_reg == ST_READ);
        cmd.load_out  = (state_reg == ST_OUT) && out_free;
    end

    // State register and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (stat.clr_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (stat.enable && stat.bin_change) begin
                        state_reg <= ST_DIV_START;
                    end else begin
                        state_reg <= ST_READ;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    if (stat.div_done) begin
                        state_reg <= ST_DIV_END;
                    end
                end
                ST_DIV_END: begin
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase

            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // A new result appears only when leaving the output state.
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result became valid outside the output state");

    // Work on an item starts only right after it was accepted.
    a_acc_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> $past(state_reg == ST_IDLE && s_valid))
        else $error("accumulate state entered without an accepted item");

    // A waiting result stays valid until the receiver takes it.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("result dropped before it was taken");

endmodule

[rtl/eebr_datapath.sv]
// Datapath of the encoder error bin recorder: accumulator, iterative divider,
// correction table memory, query read and result register. Depends on eebr_pkg.
module eebr_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  eebr_pkg::cmd_t                    cmd,
    output eebr_pkg::stat_t                   stat,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic signed [eebr_pkg::POS_W-1:0] s_motor_position,
    input  logic signed [eebr_pkg::POS_W-1:0] s_encoder_position,
    input  logic [eebr_pkg::BIN_W-1:0]        s_bin_now,
    input  logic [eebr_pkg::BIN_W-1:0]        s_query_index,
    output logic signed [eebr_pkg::CORR_W-1:0] m_correction,
    output logic                              m_table_written,
    output logic [eebr_pkg::BIN_W-1:0]        m_written_bin,
    output logic signed [eebr_pkg::CORR_W-1:0] m_query_value
);
    import eebr_pkg::*;

    // Item capture.
    logic [POS_W-1:0] diff_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [BIN_W-1:0] query_reg;

    // Recorder state.
    logic                     record_en_reg;
    logic [POS_W-1:0]         diff_sum_reg;
    logic [POS_W-1:0]         count_reg;
    logic [BIN_W-1:0]         prev_bin_reg;
    logic signed [CORR_W-1:0] corr_reg;
    logic                     written_reg;
    logic [BIN_W-1:0]         wbin_reg;

    // Divider.
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  quo_reg;
    logic [POS_W-1:0]  divisor_reg;
    logic              neg_reg;
    logic              div_zero_reg;
    logic [DIV_CW-1:0] step_reg;
    logic [POS_W:0]    trial;
    logic [POS_W:0]    shifted;
    logic [POS_W-1:0]  sum_mag;

    // Table.
    logic signed [CORR_W-1:0] table_mem [TABLE_SIZE];
    logic [TBL_AW-1:0]        clr_addr_reg;
    logic signed [CORR_W-1:0] rd_data_reg;
    logic                     query_oob_reg;
    logic                     tbl_we;
    logic [TBL_AW-1:0]        tbl_waddr;
    logic signed [CORR_W-1:0] tbl_wdata;
    logic                     bin_writable;

    // Correction from the quotient.
    logic [CORR_W-2:0]        mag_clamped;
    logic signed [CORR_W-1:0] corr_new;

    // Result register.
    logic signed [CORR_W-1:0] out_corr_reg;
    logic                     out_written_reg;
    logic [BIN_W-1:0]         out_wbin_reg;
    logic signed [CORR_W-1:0] out_qval_reg;

    assign stat.enable     = record_en_reg;
    assign stat.bin_change = (bin_reg != prev_bin_reg);
    assign stat.div_done   = (step_reg == DIV_CW'(DIV_STEPS - 1));
    assign stat.clr_done   = (clr_addr_reg == TBL_AW'(TABLE_SIZE - 1));

    // Magnitude of the signed sum; the most negative sum maps to 2^31 exactly.
    assign sum_mag = diff_sum_reg[POS_W-1] ? (~diff_sum_reg + POS_W'(1)) : diff_sum_reg;

    // Restoring division step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    // Clamp the quotient magnitude, then restore the sign (truncation toward zero).
    assign mag_clamped = (|quo_reg[POS_W-1:CORR_W-1]) ? CORR_MAG_MAX : quo_reg[CORR_W-2:0];
    always_comb begin
        if (div_zero_reg) begin
            corr_new = '0;
        end else if (neg_reg) begin
            corr_new = -$signed({1'b0, mag_clamped});
        end else begin
            corr_new = $signed({1'b0, mag_clamped});
        end
    end

    // A bin is stored unless it is zero or lies beyond the table.
    assign bin_writable = (prev_bin_reg != '0) && (32'(prev_bin_reg) < TABLE_SIZE);

    // Single table write port shared by the clear sweep and the correction write.
    always_comb begin
        if (cmd.tbl_clear) begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_addr_reg;
            tbl_wdata = NO_DATA_MARK;
        end else begin
            tbl_we    = cmd.div_end && bin_writable;
            tbl_waddr = TBL_AW'(prev_bin_reg);
            tbl_wdata = corr_new;
        end
    end

    // Table memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.rd_query) begin
            rd_data_reg   <= table_mem[TBL_AW'(query_reg)];
            query_oob_reg <= !(32'(query_reg) < TABLE_SIZE);
        end
    end

    // Item capture, divider working registers and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            diff_reg    <= s_motor_position - s_encoder_position;
            bin_reg     <= s_bin_now;
            query_reg   <= s_query_index;
            written_reg <= 1'b0;
            wbin_reg    <= '0;
        end else if (cmd.div_end && bin_writable) begin
            written_reg <= 1'b1;
            wbin_reg    <= prev_bin_reg;
        end

        if (cmd.div_start) begin
            rem_reg      <= '0;
            quo_reg      <= sum_mag;
            divisor_reg  <= count_reg;
            neg_reg      <= diff_sum_reg[POS_W-1];
            div_zero_reg <= (count_reg == '0);
        end else if (cmd.div_step) begin
            if (!trial[POS_W]) begin
                rem_reg <= trial[POS_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[POS_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], 1'b0};
            end
        end

        if (cmd.load_out) begin
            out_corr_reg    <= corr_reg;
            out_written_reg <= written_reg;
            out_wbin_reg    <= wbin_reg;
            out_qval_reg    <= query_oob_reg ? NO_DATA_MARK : rd_data_reg;
        end
    end

    // Recorder state, configuration and sequencing counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_en_reg <= 1'b1;
            diff_sum_reg  <= '0;
            count_reg     <= '0;
            prev_bin_reg  <= '0;
            corr_reg      <= '0;
            clr_addr_reg  <= '0;
            step_reg      <= '0;
        end else begin
            if (cfg_we) begin
                record_en_reg <= cfg_wdata;
            end

            if (cmd.accumulate) begin
                diff_sum_reg <= diff_sum_reg + diff_reg;
                count_reg    <= count_reg + POS_W'(1);
            end else if (cmd.div_end) begin
                diff_sum_reg <= '0;
                count_reg    <= '0;
                prev_bin_reg <= bin_reg;
                corr_reg     <= corr_new;
            end

            if (cmd.tbl_clear) begin
                clr_addr_reg <= clr_addr_reg + TBL_AW'(1);
            end

            if (cmd.div_start) begin
                step_reg <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + DIV_CW'(1);
            end
        end
    end

    assign m_correction    = out_corr_reg;
    assign m_table_written = out_written_reg;
    assign m_written_bin   = out_wbin_reg;
    assign m_query_value   = out_qval_reg;

    // The clamp never lets the held correction reach the no-data marker.
    a_corr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        corr_reg != NO_DATA_MARK)
        else $error("held correction outside the clamp range");

    // A recorded table write never names bin zero.
    a_written_bin_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        written_reg |-> (wbin_reg != '0))
        else $error("table write reported for bin zero");

    // A result that wrote nothing reports bin zero.
    a_no_write_bin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_written_reg |-> (out_wbin_reg == '0))
        else $error("written bin reported without a table write");

endmodule

[bench/encoder_error_bin_recorder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the encoder error bin recorder.
// Sends sample items over valid/ready and checks each result against a local predictor or a hand-written result.
// Depends on eebr_pkg and the encoder_error_bin_recorder RTL.
module encoder_error_bin_recorder_tb;
    import eebr_pkg::*;

    // Cycles with no handshake on either channel before the run is declared hung.
    // This covers the table clearing pass after reset and the long receiver hold.
    localparam int     STALL_LIMIT = 20000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     END_SETTLE  = 60;
    localparam longint CORR_LIM    = longint'(CORR_MAG_MAX);

    typedef struct packed {
        logic signed [POS_W-1:0] motor_position;
        logic signed [POS_W-1:0] encoder_position;
        logic [BIN_W-1:0]        bin_now;
        logic [BIN_W-1:0]        query_index;
    } sample_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic                     table_written;
        logic [BIN_W-1:0]         written_bin;
        logic signed [CORR_W-1:0] query_value;
    } bin_result_t;

    // One row of the directed sequence; has_result marks a hand-written result.
    typedef struct packed {
        logic        record_en;
        sample_t     sample;
        logic        has_result;
        bin_result_t result;
    } probe_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic                     cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [POS_W-1:0]  s_motor_position;
    logic signed [POS_W-1:0]  s_encoder_position;
    logic [BIN_W-1:0]         s_bin_now;
    logic [BIN_W-1:0]         s_query_index;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [CORR_W-1:0] m_correction;
    logic                     m_table_written;
    logic [BIN_W-1:0]         m_written_bin;
    logic signed [CORR_W-1:0] m_query_value;

    // Predictor state: the recorder as it should be after every accepted item.
    bit                       rec_enable;
    bit [POS_W-1:0]           bin_sum;
    bit [POS_W-1:0]           bin_count;
    bit [BIN_W-1:0]           cur_bin;
    logic signed [CORR_W-1:0] cur_corr;
    logic signed [CORR_W-1:0] corr_table [TABLE_SIZE];

    bin_result_t recorder_results_q [$];
    probe_row_t  probe_rows [$];
    int          fail_count = 0;
    int          gap_max    = 5;
    bit          hold_go    = 1'b0;
    bit          hold_rx    = 1'b0;

    encoder_error_bin_recorder u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_motor_position   (s_motor_position),
        .s_encoder_position (s_encoder_position),
        .s_bin_now          (s_bin_now),
        .s_query_index      (s_query_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_correction       (m_correction),
        .m_table_written    (m_table_written),
        .m_written_bin      (m_written_bin),
        .m_query_value      (m_query_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // While recording is enabled, accumulates one sample and closes the bin when the encoder moves to another one.
    function automatic bin_result_t predict_bin_result(sample_t smp);
        bin_result_t res;
        longint      mean;
        res = '0;
        if (rec_enable) begin
            bin_sum   = bin_sum + smp.motor_position - smp.encoder_position;
            bin_count = bin_count + 1;
            if (smp.bin_now != cur_bin) begin
                // Mean of the bin, truncated toward zero; a wrapped count gives zero.
                mean = 0;
                if (bin_count != 0)
                    mean = longint'($signed(bin_sum)) / longint'(bin_count);
                if (mean > CORR_LIM)
                    mean = CORR_LIM;
                if (mean < -CORR_LIM)
                    mean = -CORR_LIM;
                cur_corr = mean[CORR_W-1:0];
                // Bin zero is never stored.
                if (cur_bin != 0 && int'(cur_bin) < TABLE_SIZE) begin
                    corr_table[cur_bin] = cur_corr;
                    res.table_written   = 1'b1;
                    res.written_bin     = cur_bin;
                end
                bin_sum   = '0;
                bin_count = '0;
                cur_bin   = smp.bin_now;
            end
        end
        res.correction  = cur_corr;
        res.query_value = (int'(smp.query_index) < TABLE_SIZE) ?
                          corr_table[smp.query_index] : NO_DATA_MARK;
        return res;
    endfunction

    function automatic void add_probe(bit en, logic signed [POS_W-1:0] motor,
                                      logic signed [POS_W-1:0] enc, int bin, int query,
                                      bit has_res, int corr, bit wr, int wbin, int qv);
        probe_row_t row;
        row.record_en                = en;
        row.sample.motor_position    = motor;
        row.sample.encoder_position  = enc;
        row.sample.bin_now           = BIN_W'(bin);
        row.sample.query_index       = BIN_W'(query);
        row.has_result               = has_res;
        row.result.correction        = CORR_W'(corr);
        row.result.table_written     = wr;
        row.result.written_bin       = BIN_W'(wbin);
        row.result.query_value       = CORR_W'(qv);
        probe_rows.push_back(row);
    endfunction

    // Offers one item after a random gap and returns at the edge that accepts it.
    task automatic send_sample(sample_t smp);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_motor_position   <= smp.motor_position;
        s_encoder_position <= smp.encoder_position;
        s_bin_now          <= smp.bin_now;
        s_query_index      <= smp.query_index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every expected result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (recorder_results_q.size() != 0) @(posedge aclk);
    endtask

    // The register is only written while the recorder is idle.
    task automatic write_record_enable(bit en);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        rec_enable = en;
    endtask

    // Result side ready: a random wait per item, plus the long hold when requested.
    initial begin : result_sink
        int wait_left;
        m_ready  <= 1'b0;
        wait_left = $urandom_range(0, gap_max);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                wait_left = $urandom_range(0, gap_max);
            else if (wait_left > 0)
                wait_left--;
            m_ready <= (wait_left == 0) && !hold_rx;
        end
    end

    // Holds the result side off long enough for the recorder to back up its input.
    initial begin : result_hold
        wait (hold_go);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Compares each accepted result with the oldest expectation.
    initial begin : result_check
        bin_result_t exp;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (recorder_results_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    exp = recorder_results_q.pop_front();
                    if (m_correction !== exp.correction) begin
                        $error("correction: expected %0d, got %0d",
                               exp.correction, m_correction);
                        fail_count++;
                    end
                    if (m_table_written !== exp.table_written) begin
                        $error("table_written: expected %0d, got %0d",
                               exp.table_written, m_table_written);
                        fail_count++;
                    end
                    if (m_written_bin !== exp.written_bin) begin
                        $error("written_bin: expected %0d, got %0d",
                               exp.written_bin, m_written_bin);
                        fail_count++;
                    end
                    if (m_query_value !== exp.query_value) begin
                        $error("query_value: expected %0d, got %0d",
                               exp.query_value, m_query_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        sample_t          smp;
        bin_result_t      res;
        int               phase_items;
        int               seg_left;
        logic [BIN_W-1:0] seg_bin;
        logic [BIN_W-1:0] prior_bin;
        bit               phase_en;

        aresetn            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 1'b0;
        s_valid            <= 1'b0;
        s_motor_position   <= '0;
        s_encoder_position <= '0;
        s_bin_now          <= '0;
        s_query_index      <= '0;

        rec_enable = 1'b1;
        bin_sum    = '0;
        bin_count  = '0;
        cur_bin    = '0;
        cur_corr   = '0;
        foreach (corr_table[i])
            corr_table[i] = NO_DATA_MARK;

        // Directed rows: en, motor, encoder, bin, query, then the result where it is obvious.
        // Same bin as after reset, then a change away from bin zero (nothing stored).
        add_probe(1, 0, 0, 0, 0, 1, 0, 0, 0, -32768);
        add_probe(1, 5, 0, 5, 5, 1, 2, 0, 0, -32768);
        // Large positive mean clamps high, large negative mean clamps low.
        add_probe(1, 1000000, 0, 5, 4095, 1, 2, 0, 0, -32768);
        add_probe(1, 0, 0, 6, 5, 1, 32767, 1, 5, 32767);
        add_probe(1, -1000000, 0, 6, 0, 1, 32767, 0, 0, -32768);
        add_probe(1, 0, 0, 7, 6, 1, -32767, 1, 6, -32767);
        // Position extremes whose differences wrap around.
        add_probe(1, 32'sh7fffffff, 32'sh80000000, 7, 7, 1, -32767, 0, 0, -32768);
        add_probe(1, 32'sh80000000, 32'sh7fffffff, 7, 4095, 1, -32767, 0, 0, -32768);
        // A negative mean with a remainder truncates toward zero.
        add_probe(1, -7, 0, 7, 7, 1, -32767, 0, 0, -32768);
        add_probe(1, 0, 0, 4095, 7, 1, -1, 1, 7, -1);
        // Highest bin written, then a change into bin zero still stores the old bin.
        add_probe(1, 3, 0, 4095, 4095, 1, -1, 0, 0, -32768);
        add_probe(1, 0, 0, 1, 4095, 1, 1, 1, 4095, 1);
        add_probe(1, 100, 0, 0, 1, 1, 100, 1, 1, 100);
        add_probe(1, 50, 0, 2, 1, 1, 50, 0, 0, 100);
        // Recording off: nothing moves, reads still work.
        add_probe(0, 999, 0, 3, 2, 1, 50, 0, 0, -32768);
        add_probe(0, 32'sh7fffffff, 32'sh80000000, 4095, 4095, 1, 50, 0, 0, 1);
        // Recording back on resumes from the bin held before.
        add_probe(1, 10, 0, 2, 2, 1, 50, 0, 0, -32768);
        add_probe(1, 0, 10, 3, 2, 1, 0, 1, 2, 0);
        add_probe(1, -123456789, 987654321, 3, 3, 0, 0, 0, 0, 0);
        add_probe(1, 32'sh80000000, 0, 4094, 3, 0, 0, 0, 0, 0);
        add_probe(1, 0, 0, 3, 4094, 0, 0, 0, 0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_rows[i]) begin
            if (probe_rows[i].record_en != rec_enable)
                write_record_enable(probe_rows[i].record_en);
            send_sample(probe_rows[i].sample);
            res = predict_bin_result(probe_rows[i].sample);
            recorder_results_q.push_back(probe_rows[i].has_result ?
                                         probe_rows[i].result : res);
        end

        // Random phases: runs of samples in one bin with occasional stray bins.
        seg_left  = 0;
        seg_bin   = '0;
        prior_bin = '0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    phase_en    = 1'b1;
                    gap_max     = 5;
                    phase_items = 250;
                end
                1: begin
                    phase_en    = 1'b1;
                    gap_max     = 0;
                    phase_items = 150;
                end
                2: begin
                    phase_en    = 1'b0;
                    gap_max     = 5;
                    phase_items = 60;
                end
                default: begin
                    phase_en    = 1'b1;
                    gap_max     = 5;
                    phase_items = 340;
                end
            endcase
            write_record_enable(phase_en);
            if (ph == 1)
                hold_go = 1'b1;

            for (int n = 0; n < phase_items; n++) begin
                if (seg_left == 0) begin
                    prior_bin = seg_bin;
                    case ($urandom_range(0, 7))
                        0: seg_bin = '0;
                        1: seg_bin = BIN_W'($urandom_range(0, 4095));
                        default: seg_bin = BIN_W'($urandom_range(1, 15));
                    endcase
                    seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(1, 5);
                end
                seg_left--;
                smp.bin_now = ($urandom_range(0, 11) == 0) ? BIN_W'($urandom()) : seg_bin;
                smp.motor_position = $urandom();
                if ($urandom_range(0, 3) == 0)
                    smp.encoder_position = $urandom();
                else
                    smp.encoder_position = smp.motor_position -
                                           ($urandom_range(0, 60000) - 30000);
                case ($urandom_range(0, 3))
                    0, 1: smp.query_index = prior_bin;
                    2: smp.query_index = BIN_W'($urandom_range(0, 15));
                    default: smp.query_index = BIN_W'($urandom());
                endcase
                send_sample(smp);
                recorder_results_q.push_back(predict_bin_result(smp));
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
